// File: src/assert_macros.svh
// Shared assertion helpers for the page replacement block.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, disabled while reset is asserted.
`define ASSERT_IMPL(lbl, clk, rst_n, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("%m: implication check failed");

// Next-cycle implication, disabled while reset is asserted.
`define ASSERT_NEXT(lbl, clk, rst_n, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("%m: next-cycle check failed");

`endif

// File: src/prcl_pkg.sv
package prcl_pkg;

  typedef enum logic [1:0] {
    REQ_INSTALL = 2'd0,
    REQ_ACCESS  = 2'd1,
    REQ_VICTIM  = 2'd2,
    REQ_NOP     = 2'd3
  } req_t;

  typedef enum logic [1:0] {
    STAT_DONE  = 2'd0,
    STAT_MISS  = 2'd1,
    STAT_EMPTY = 2'd2,
    STAT_RANGE = 2'd3
  } status_t;

  // What a cell offers as a candidate during the select cycle
  typedef enum logic [2:0] {
    K_FRAME,
    K_TAG,
    K_RANK0,
    K_CLEAN_UNUSED,
    K_DIRTY_UNUSED,
    K_CLEAN,
    K_PRESENT
  } cand_t;

  typedef enum logic [1:0] {
    U_NONE,
    U_INSTALL,
    U_TOUCH,
    U_EVICT
  } upd_t;

  typedef struct packed {
    logic  sel_en;
    cand_t cand;
    upd_t  upd;
    logic  wr;
    logic  dec_en;
    logic  clr_all;
    logic  clr_passed;
  } cell_ctl_t;

  typedef struct packed {
    logic present;
    logic clean;
    logic clean_unused;
    logic dirty_unused;
  } cell_cls_t;

  localparam int CFG_ADDR_W = 3;
  localparam logic [CFG_ADDR_W-1:0] ADDR_MODE   = 3'h0;
  localparam logic [CFG_ADDR_W-1:0] ADDR_ACTIVE = 3'h4;

  localparam int ACTIVE_W = 7;
  localparam logic [ACTIVE_W-1:0] ACTIVE_RESET = 7'd64;

endpackage

// File: src/prcl_cell.sv
module prcl_cell #(
  parameter int FRAME_COUNT  = 64,
  parameter int PAGE_BITS    = 16,
  parameter int PROCESS_BITS = 8,
  parameter int IDX          = 0,
  localparam int FI_W = $clog2(FRAME_COUNT)
) (
  input  logic                     clk,
  input  logic                     rst_n,
  input  prcl_pkg::cell_ctl_t      ctl,
  input  logic [FI_W-1:0]          hand,
  input  logic [FI_W-1:0]          frame,
  input  logic [FI_W-1:0]          victim,
  input  logic [FI_W-1:0]          sel_rank,
  input  logic [FI_W-1:0]          new_rank,
  input  logic [PROCESS_BITS-1:0]  pid,
  input  logic [PAGE_BITS-1:0]     pg,
  input  logic                     found_ge_in,
  input  logic                     found_all_in,
  input  logic                     wrap,
  output logic                     found_ge_out,
  output logic                     found_all_out,
  output prcl_pkg::cell_cls_t      cls,
  output logic                     sel,
  output logic [PROCESS_BITS-1:0]  rd_proc,
  output logic [PAGE_BITS-1:0]     rd_page,
  output logic [FI_W-1:0]          rd_rank,
  output logic [FI_W-1:0]          rd_idx,
  output logic                     rd_dirty,
  output logic                     rd_present
);
  import prcl_pkg::*;

  localparam logic [FI_W-1:0] MY_IDX = FI_W'(IDX);

  logic                    present_r, used_r, dirty_r, sel_r;
  logic [PROCESS_BITS-1:0] proc_r;
  logic [PAGE_BITS-1:0]    page_r;
  logic [FI_W-1:0]         rank_r;
  logic                    cand, ge, passed, dec;

  assign ge = (MY_IDX >= hand);

  always_comb begin
    case (ctl.cand)
      K_FRAME:        cand = (MY_IDX == frame);
      K_TAG:          cand = present_r && (proc_r == pid) && (page_r == pg);
      K_RANK0:        cand = present_r && (rank_r == '0);
      K_CLEAN_UNUSED: cand = present_r && !used_r && !dirty_r;
      K_DIRTY_UNUSED: cand = present_r && !used_r && dirty_r;
      K_CLEAN:        cand = present_r && !dirty_r;
      K_PRESENT:      cand = present_r;
      default:        cand = 1'b0;
    endcase
  end

  assign found_ge_out  = found_ge_in | (cand & ge);
  assign found_all_out = found_all_in | cand;

  // frames the second sweep went over before reaching the victim
  assign passed = (victim >= hand) ? (ge && (MY_IDX < victim))
                                   : (ge || (MY_IDX < victim));
  assign dec = ctl.dec_en && !sel_r && present_r && (rank_r > sel_rank);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      present_r <= 1'b0;
      used_r    <= 1'b0;
      dirty_r   <= 1'b0;
      sel_r     <= 1'b0;
    end else begin
      if (ctl.sel_en) begin
        sel_r <= wrap ? (cand && !found_all_in) : (cand && ge && !found_ge_in);
      end
      if (ctl.upd != U_NONE && dec) begin
        rank_r <= rank_r - 1'b1;
      end
      case (ctl.upd)
        U_INSTALL: begin
          if (sel_r) begin
            present_r <= 1'b1;
            used_r    <= 1'b0;
            dirty_r   <= 1'b0;
            proc_r    <= pid;
            page_r    <= pg;
            rank_r    <= new_rank;
          end
        end
        U_TOUCH: begin
          if (sel_r) begin
            used_r  <= 1'b1;
            dirty_r <= dirty_r | ctl.wr;
            rank_r  <= new_rank;
          end
        end
        U_EVICT: begin
          if (sel_r) begin
            present_r <= 1'b0;
            used_r    <= 1'b0;
            dirty_r   <= 1'b0;
          end else if (ctl.clr_all || (ctl.clr_passed && passed && present_r)) begin
            used_r <= 1'b0;
          end
        end
        default: ;
      endcase
    end
  end

  assign cls.present      = present_r;
  assign cls.clean        = present_r && !dirty_r;
  assign cls.clean_unused = present_r && !used_r && !dirty_r;
  assign cls.dirty_unused = present_r && !used_r && dirty_r;

  assign sel        = sel_r;
  assign rd_proc    = sel_r ? proc_r : '0;
  assign rd_page    = sel_r ? page_r : '0;
  assign rd_rank    = sel_r ? rank_r : '0;
  assign rd_idx     = sel_r ? MY_IDX : '0;
  assign rd_dirty   = sel_r & dirty_r;
  assign rd_present = sel_r & present_r;

endmodule

// File: src/page_replacement_clockm_lru.sv
// Each item passes the class, select, read and update states before out_tvalid
// rises; the result holds until the output transfer completes.
// A new item is taken only once the output transfer of the last one completes;
// the select and update passes run across the whole row of frame cells.
// Reset (synchronous, rst_n low): all frames absent, hand and count zero,
// mode clock-modified, active frames 64.
module page_replacement_clockm_lru #(
  parameter int FRAME_COUNT  = 64,
  parameter int PAGE_BITS    = 16,
  parameter int PROCESS_BITS = 8,
  localparam int FI_W   = $clog2(FRAME_COUNT),
  localparam int CNT_W  = $clog2(FRAME_COUNT + 1),
  localparam int IN_W   = 3 + FI_W + PROCESS_BITS + PAGE_BITS,
  localparam int IN_TW  = ((IN_W + 7) / 8) * 8,
  localparam int OUT_W  = 3 + FI_W + PROCESS_BITS + PAGE_BITS + CNT_W,
  localparam int OUT_TW = ((OUT_W + 7) / 8) * 8
) (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic                              in_tvalid,
  output logic                              in_tready,
  // req_type, is_write, frame_index, process_id, page_number (low to high)
  input  logic [IN_TW-1:0]                  in_tdata,
  output logic                              out_tvalid,
  input  logic                              out_tready,
  // status, victim_frame, victim_process, victim_page, victim_dirty,
  // resident_pages (low to high)
  output logic [OUT_TW-1:0]                 out_tdata,
  input  logic                              cfg_psel,
  input  logic                              cfg_penable,
  input  logic                              cfg_pwrite,
  input  logic [prcl_pkg::CFG_ADDR_W-1:0]   cfg_paddr,
  input  logic [31:0]                       cfg_pwdata,
  output logic [31:0]                       cfg_prdata,
  output logic                              cfg_pready
);
  import prcl_pkg::*;
  `include "assert_macros.svh"

  typedef enum logic [2:0] {S_IDLE, S_CLS, S_SEL, S_RD, S_UPD, S_OUT} state_t;

  state_t                  state_r;
  logic                    mode_r;
  logic [ACTIVE_W-1:0]     active_r;
  logic [FI_W-1:0]         hand_r;
  logic [CNT_W-1:0]        count_r;

  req_t                    req_r;
  logic                    wr_r;
  logic [FI_W-1:0]         frame_r;
  logic [PROCESS_BITS-1:0] pid_r;
  logic [PAGE_BITS-1:0]    pg_r;

  logic any_cu_r, any_du_r, any_clean_r, range_ok_r;
  logic found_r, rd_present_r, rd_dirty_r;
  logic [PROCESS_BITS-1:0] rd_proc_r;
  logic [PAGE_BITS-1:0]    rd_page_r;
  logic [FI_W-1:0]         rd_rank_r, rd_idx_r;

  logic [1:0]              o_status_r;
  logic [FI_W-1:0]         o_frame_r;
  logic [PROCESS_BITS-1:0] o_proc_r;
  logic [PAGE_BITS-1:0]    o_page_r;
  logic                    o_dirty_r;
  logic [CNT_W-1:0]        o_count_r;

  cell_ctl_t               ctl;
  logic [FI_W-1:0]         hand_eff, new_rank;
  logic                    clock_victim;

  logic [FRAME_COUNT:0]    fge, fall;
  cell_cls_t               cls   [FRAME_COUNT];
  logic [FRAME_COUNT-1:0]  sel_vec, pres_vec, dirty_vec, cellp_vec, clean_vec, cu_vec, du_vec;
  logic [PROCESS_BITS-1:0] c_proc [FRAME_COUNT];
  logic [PAGE_BITS-1:0]    c_page [FRAME_COUNT];
  logic [FI_W-1:0]         c_rank [FRAME_COUNT];
  logic [FI_W-1:0]         c_idx  [FRAME_COUNT];

  logic [PROCESS_BITS-1:0] or_proc;
  logic [PAGE_BITS-1:0]    or_page;
  logic [FI_W-1:0]         or_rank, or_idx;

  logic                    in_xfer, cfg_wr, do_upd;
  logic [CNT_W-1:0]        count_nxt;
  logic [FI_W-1:0]         hand_nxt;

  assign in_xfer    = in_tvalid && in_tready;
  assign cfg_wr     = cfg_psel && cfg_penable && cfg_pwrite && cfg_pready;
  assign in_tready  = (state_r == S_IDLE);
  assign out_tvalid = (state_r == S_OUT);
  assign cfg_pready = 1'b1;

  always_comb begin
    case (cfg_paddr)
      ADDR_MODE:   cfg_prdata = {31'd0, mode_r};
      ADDR_ACTIVE: cfg_prdata = {{(32 - ACTIVE_W){1'b0}}, active_r};
      default:     cfg_prdata = '0;
    endcase
  end

  assign clock_victim = (req_r == REQ_VICTIM) && !mode_r;
  assign hand_eff     = clock_victim ? hand_r : '0;

  // cell control for each phase
  always_comb begin
    ctl            = '0;
    ctl.cand       = K_FRAME;
    ctl.upd        = U_NONE;
    ctl.wr         = wr_r;
    ctl.sel_en     = (state_r == S_SEL);
    new_rank       = FI_W'(count_r - 1'b1);
    case (req_r)
      REQ_ACCESS: ctl.cand = K_TAG;
      REQ_VICTIM: begin
        if (mode_r)            ctl.cand = K_RANK0;
        else if (any_cu_r)     ctl.cand = K_CLEAN_UNUSED;
        else if (any_du_r)     ctl.cand = K_DIRTY_UNUSED;
        else if (any_clean_r)  ctl.cand = K_CLEAN;
        else                   ctl.cand = K_PRESENT;
      end
      default: ctl.cand = K_FRAME;
    endcase
    if (req_r == REQ_INSTALL && !rd_present_r) begin
      new_rank = FI_W'(count_r);
    end
    if (state_r == S_UPD && do_upd) begin
      case (req_r)
        REQ_INSTALL: begin
          ctl.upd    = U_INSTALL;
          ctl.dec_en = rd_present_r;
        end
        REQ_ACCESS: begin
          ctl.upd    = U_TOUCH;
          ctl.dec_en = 1'b1;
        end
        REQ_VICTIM: begin
          ctl.upd        = U_EVICT;
          ctl.dec_en     = 1'b1;
          ctl.clr_all    = clock_victim && !any_cu_r && !any_du_r;
          ctl.clr_passed = clock_victim && !any_cu_r && any_du_r;
        end
        default: ctl.upd = U_NONE;
      endcase
    end
  end

  assign fge[0]  = 1'b0;
  assign fall[0] = 1'b0;

  for (genvar i = 0; i < FRAME_COUNT; i++) begin : g_cell
    prcl_cell #(
      .FRAME_COUNT (FRAME_COUNT),
      .PAGE_BITS   (PAGE_BITS),
      .PROCESS_BITS(PROCESS_BITS),
      .IDX         (i)
    ) u_cell (
      .clk          (clk),
      .rst_n        (rst_n),
      .ctl          (ctl),
      .hand         (hand_eff),
      .frame        (frame_r),
      .victim       (rd_idx_r),
      .sel_rank     (rd_rank_r),
      .new_rank     (new_rank),
      .pid          (pid_r),
      .pg           (pg_r),
      .found_ge_in  (fge[i]),
      .found_all_in (fall[i]),
      .wrap         (!fge[FRAME_COUNT]),
      .found_ge_out (fge[i+1]),
      .found_all_out(fall[i+1]),
      .cls          (cls[i]),
      .sel          (sel_vec[i]),
      .rd_proc      (c_proc[i]),
      .rd_page      (c_page[i]),
      .rd_rank      (c_rank[i]),
      .rd_idx       (c_idx[i]),
      .rd_dirty     (dirty_vec[i]),
      .rd_present   (cellp_vec[i])
    );
    assign pres_vec[i]  = cls[i].present;
    assign clean_vec[i] = cls[i].clean;
    assign cu_vec[i]    = cls[i].clean_unused;
    assign du_vec[i]    = cls[i].dirty_unused;
  end

  // at most one cell is selected, so an OR gathers its fields
  always_comb begin
    or_proc = '0;
    or_page = '0;
    or_rank = '0;
    or_idx  = '0;
    for (int i = 0; i < FRAME_COUNT; i++) begin
      or_proc = or_proc | c_proc[i];
      or_page = or_page | c_page[i];
      or_rank = or_rank | c_rank[i];
      or_idx  = or_idx | c_idx[i];
    end
  end

  always_comb begin
    case (req_r)
      REQ_INSTALL: do_upd = range_ok_r;
      REQ_ACCESS:  do_upd = found_r;
      REQ_VICTIM:  do_upd = found_r;
      default:     do_upd = 1'b0;
    endcase
    count_nxt = count_r;
    hand_nxt  = hand_r;
    if (do_upd && req_r == REQ_INSTALL && !rd_present_r) begin
      count_nxt = count_r + 1'b1;
    end
    if (do_upd && req_r == REQ_VICTIM) begin
      count_nxt = count_r - 1'b1;
      hand_nxt  = (rd_idx_r == FI_W'(FRAME_COUNT - 1)) ? '0 : rd_idx_r + 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r  <= S_IDLE;
      mode_r   <= 1'b0;
      active_r <= ACTIVE_RESET;
      hand_r   <= '0;
      count_r  <= '0;
    end else begin
      if (cfg_wr) begin
        case (cfg_paddr)
          ADDR_MODE:   mode_r   <= cfg_pwdata[0];
          ADDR_ACTIVE: active_r <= cfg_pwdata[ACTIVE_W-1:0];
          default: ;
        endcase
      end
      case (state_r)
        S_IDLE: begin
          if (in_xfer) begin
            req_r   <= req_t'(in_tdata[1:0]);
            wr_r    <= in_tdata[2];
            frame_r <= in_tdata[3 +: FI_W];
            pid_r   <= in_tdata[3 + FI_W +: PROCESS_BITS];
            pg_r    <= in_tdata[3 + FI_W + PROCESS_BITS +: PAGE_BITS];
            state_r <= S_CLS;
          end
        end
        S_CLS: begin
          any_cu_r    <= |cu_vec;
          any_du_r    <= |du_vec;
          any_clean_r <= |clean_vec;
          range_ok_r  <= (32'(frame_r) < 32'(active_r));
          state_r     <= S_SEL;
        end
        S_SEL: state_r <= S_RD;
        S_RD: begin
          found_r      <= |sel_vec;
          rd_present_r <= |cellp_vec;
          rd_dirty_r   <= |dirty_vec;
          rd_proc_r    <= or_proc;
          rd_page_r    <= or_page;
          rd_rank_r    <= or_rank;
          rd_idx_r     <= or_idx;
          state_r      <= S_UPD;
        end
        S_UPD: begin
          count_r    <= count_nxt;
          hand_r     <= hand_nxt;
          o_count_r  <= count_nxt;
          o_status_r <= STAT_DONE;
          o_frame_r  <= '0;
          o_proc_r   <= '0;
          o_page_r   <= '0;
          o_dirty_r  <= 1'b0;
          case (req_r)
            REQ_INSTALL: begin
              if (!range_ok_r) begin
                o_status_r <= STAT_RANGE;
              end else begin
                o_frame_r <= frame_r;
                o_proc_r  <= pid_r;
                o_page_r  <= pg_r;
              end
            end
            REQ_ACCESS: begin
              if (!found_r) begin
                o_status_r <= STAT_MISS;
              end else begin
                o_frame_r <= rd_idx_r;
                o_proc_r  <= rd_proc_r;
                o_page_r  <= rd_page_r;
                o_dirty_r <= rd_dirty_r | wr_r;
              end
            end
            REQ_VICTIM: begin
              if (!found_r) begin
                o_status_r <= STAT_EMPTY;
              end else begin
                o_frame_r <= rd_idx_r;
                o_proc_r  <= rd_proc_r;
                o_page_r  <= rd_page_r;
                o_dirty_r <= rd_dirty_r;
              end
            end
            default: ;
          endcase
          state_r <= S_OUT;
        end
        S_OUT: begin
          if (out_tready) begin
            state_r <= S_IDLE;
          end
        end
        default: state_r <= S_IDLE;
      endcase
    end
  end

  assign out_tdata = {{(OUT_TW - OUT_W){1'b0}}, o_count_r, o_dirty_r, o_page_r, o_proc_r,
                      o_frame_r, o_status_r};

  `ASSERT_IMPL(a_count_max, clk, rst_n, 1'b1, 32'(count_r) <= FRAME_COUNT)
  `ASSERT_IMPL(a_sel_single, clk, rst_n, state_r == S_RD, $onehot0(sel_vec))
  `ASSERT_IMPL(a_count_match, clk, rst_n, state_r == S_IDLE,
               $countones(pres_vec) == 32'(count_r))
  `ASSERT_NEXT(a_accept_busy, clk, rst_n, in_xfer, state_r == S_CLS && !out_tvalid)

endmodule

// File: test/page_replacement_clockm_lru_checker.sv
`timescale 1ns / 1ps

module page_replacement_clockm_lru_checker
  import prcl_pkg::*;
(
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  input  logic        in_tready,
  input  logic [39:0] in_tdata,
  input  logic        out_tvalid,
  input  logic        out_tready,
  input  logic [39:0] out_tdata,
  input  logic        cfg_psel,
  input  logic        cfg_penable,
  input  logic        cfg_pwrite,
  input  logic [CFG_ADDR_W-1:0] cfg_paddr,
  input  logic [31:0] cfg_pwdata,
  input  logic        cfg_pready,
  output int          errors,
  output int          pending
);

  typedef struct {
    status_t     status;
    logic [5:0]  frame;
    logic [7:0]  pid;
    logic [15:0] page;
    logic        dirty;
    logic [6:0]  resident;
  } victim_report_t;

  victim_report_t report_q[$];

  logic        lru_mode;
  logic [6:0]  active_lim;
  logic        present[64];
  logic        used[64];
  logic        dirty[64];
  logic [7:0]  tag_pid[64];
  logic [15:0] tag_page[64];
  int          rank[64];
  int          hand;
  int          resident;

  task automatic report(string field, int got, int want);
    $display("%0t: %s got 0x%0h want 0x%0h", $realtime, field, got, want);
    errors++;
  endtask

  // Close the gap left by frame f in the recency order.
  function automatic void unrank(int f);
    for (int g = 0; g < 64; g++)
      if (g != f && present[g] && rank[g] > rank[f]) rank[g]--;
  endfunction

  function automatic victim_report_t predict_victim_report(logic [39:0] d);
    victim_report_t r;
    req_t        req;
    logic        wr;
    int          fi, v;
    logic [7:0]  pid;
    logic [15:0] pg;
    logic        found, second;
    req = req_t'(d[1:0]);
    wr  = d[2];
    fi  = d[8:3];
    pid = d[16:9];
    pg  = d[32:17];
    r = '{STAT_DONE, 0, 0, 0, 0, 0};
    found = 0;
    v = 0;
    case (req)
      REQ_INSTALL: begin
        if (fi >= active_lim) begin
          r.status = STAT_RANGE;
        end else begin
          if (present[fi]) begin
            unrank(fi);
            rank[fi] = resident - 1;
          end else begin
            rank[fi] = resident;
            present[fi] = 1;
            resident++;
          end
          used[fi] = 0;
          dirty[fi] = 0;
          tag_pid[fi] = pid;
          tag_page[fi] = pg;
          r.frame = fi;
          r.pid = pid;
          r.page = pg;
        end
      end
      REQ_ACCESS: begin
        for (int f = 0; f < 64; f++)
          if (!found && present[f] && tag_pid[f] == pid && tag_page[f] == pg) begin
            found = 1;
            v = f;
          end
        if (!found) begin
          r.status = STAT_MISS;
        end else begin
          used[v] = 1;
          if (wr) dirty[v] = 1;
          unrank(v);
          rank[v] = resident - 1;
          r.frame = v;
          r.pid = tag_pid[v];
          r.page = tag_page[v];
          r.dirty = dirty[v];
        end
      end
      REQ_VICTIM: begin
        if (lru_mode) begin
          for (int f = 0; f < 64; f++)
            if (present[f] && (!found || rank[f] < rank[v])) begin
              v = f;
              found = 1;
            end
        end else begin
          // Clean pass, then dirty pass that clears use bits; repeat once.
          for (int rnd = 0; rnd < 4; rnd++) begin
            second = rnd[0];
            for (int k = 0; k < 64; k++) begin
              int f;
              f = (hand + k) % 64;
              if (!found && present[f]) begin
                if (!used[f] && dirty[f] == second) begin
                  v = f;
                  found = 1;
                end else if (second) begin
                  used[f] = 0;
                end
              end
            end
          end
        end
        if (!found) begin
          r.status = STAT_EMPTY;
        end else begin
          r.frame = v;
          r.pid = tag_pid[v];
          r.page = tag_page[v];
          r.dirty = dirty[v];
          unrank(v);
          present[v] = 0;
          used[v] = 0;
          dirty[v] = 0;
          if (resident > 0) resident--;
          hand = (v + 1) % 64;
        end
      end
      default: ;
    endcase
    r.resident = resident;
    return r;
  endfunction

  always @(posedge clk) begin
    if (!rst_n) begin
      lru_mode = 0;
      active_lim = 64;
      for (int f = 0; f < 64; f++) begin
        present[f] = 0;
        used[f] = 0;
        dirty[f] = 0;
        rank[f] = 0;
      end
      hand = 0;
      resident = 0;
      report_q.delete();
    end else begin
      if (cfg_psel && cfg_penable && cfg_pwrite && cfg_pready) begin
        if (cfg_paddr == ADDR_MODE) lru_mode = cfg_pwdata[0];
        else if (cfg_paddr == ADDR_ACTIVE) active_lim = cfg_pwdata[6:0];
      end
      if (in_tvalid && in_tready) report_q.push_back(predict_victim_report(in_tdata));
      if (out_tvalid && out_tready) begin
        if (report_q.size() == 0) begin
          report("unexpected transfer", out_tdata, 0);
        end else begin
          victim_report_t w;
          w = report_q.pop_front();
          if (out_tdata[1:0] !== w.status) report("status", out_tdata[1:0], w.status);
          if (out_tdata[7:2] !== w.frame) report("victim_frame", out_tdata[7:2], w.frame);
          if (out_tdata[15:8] !== w.pid) report("victim_process", out_tdata[15:8], w.pid);
          if (out_tdata[31:16] !== w.page) report("victim_page", out_tdata[31:16], w.page);
          if (out_tdata[32] !== w.dirty) report("victim_dirty", out_tdata[32], w.dirty);
          if (out_tdata[39:33] !== w.resident)
            report("resident_pages", out_tdata[39:33], w.resident);
        end
      end
    end
    pending = report_q.size();
  end

  initial begin
    errors = 0;
    pending = 0;
  end

endmodule

// File: test/page_replacement_clockm_lru_tb.sv
`timescale 1ns / 1ps

module page_replacement_clockm_lru_tb;
  import prcl_pkg::*;

  logic        clk = 0;
  logic        rst_n = 0;
  logic        in_tvalid = 0;
  logic        in_tready;
  // req_type, is_write, frame_index, process_id, page_number (low to high)
  logic [39:0] in_tdata = '0;
  logic        out_tvalid;
  logic        out_tready = 0;
  // status, victim_frame, victim_process, victim_page, victim_dirty,
  // resident_pages (low to high)
  logic [39:0] out_tdata;
  logic        cfg_psel = 0;
  logic        cfg_penable = 0;
  logic        cfg_pwrite = 0;
  logic [CFG_ADDR_W-1:0] cfg_paddr = '0;
  logic [31:0] cfg_pwdata = '0;
  logic [31:0] cfg_prdata;
  logic        cfg_pready;
  int          errors;
  int          pending;
  int          cycles = 0;
  int          rx_cycles = 0;
  logic        steady = 0;
  int          act = 64;
  logic        known[64];
  logic [7:0]  known_pid[64];
  logic [15:0] known_pg[64];

  always #6 clk = ~clk;

  page_replacement_clockm_lru dut (.*);

  page_replacement_clockm_lru_checker checker_i (.*);

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > 2000000) begin
      $display("SCOREBOARD MISMATCH");
      $finish;
    end
  end

  // Receiver: random stalls, one long hold-off, and a quiet stretch.
  always @(posedge clk) begin
    if (rst_n) rx_cycles <= rx_cycles + 1;
    if (rx_cycles >= 3000 && rx_cycles < 3400) out_tready <= 0;
    else if (steady) out_tready <= 1;
    else out_tready <= ($urandom_range(99) >= 14);
  end

  task automatic send(req_t req, logic wr, int fi, logic [7:0] pid, logic [15:0] pg);
    while (!steady && $urandom_range(99) < 14) begin
      in_tvalid <= 0;
      @(posedge clk);
    end
    in_tvalid <= 1;
    in_tdata <= {7'd0, pg, pid, fi[5:0], wr, req};
    if (req == REQ_INSTALL && fi < act) begin
      known[fi] = 1;
      known_pid[fi] = pid;
      known_pg[fi] = pg;
    end
    @(posedge clk);
    while (!in_tready) @(posedge clk);
  endtask

  task automatic cfg_write(logic [CFG_ADDR_W-1:0] addr, int val);
    cfg_psel <= 1;
    cfg_pwrite <= 1;
    cfg_penable <= 0;
    cfg_paddr <= addr;
    cfg_pwdata <= val;
    @(posedge clk);
    cfg_penable <= 1;
    @(posedge clk);
    cfg_psel <= 0;
    cfg_penable <= 0;
    cfg_pwrite <= 0;
  endtask

  // Drain outstanding work before touching the registers.
  task automatic set_phase(logic mode, int frames);
    in_tvalid <= 0;
    @(posedge clk);
    while (pending != 0) @(posedge clk);
    repeat (10) @(posedge clk);
    cfg_write(ADDR_MODE, mode);
    cfg_write(ADDR_ACTIVE, frames);
    act = frames;
  endtask

  task automatic random_items(int n);
    int r, fi, k;
    for (int i = 0; i < n; i++) begin
      steady = (i >= 100 && i < 160);
      r = $urandom_range(99);
      if ($urandom_range(9) == 0) fi = $urandom_range(63);
      else fi = $urandom_range(act - 1);
      if (r < 38) begin
        send(REQ_INSTALL, $urandom_range(1), fi, $urandom_range(3) == 0 ? $urandom_range(255)
             : $urandom_range(3), $urandom);
      end else if (r < 72) begin
        k = $urandom_range(63);
        if (known[k] && $urandom_range(4) != 0)
          send(REQ_ACCESS, $urandom_range(1), $urandom_range(63), known_pid[k], known_pg[k]);
        else
          send(REQ_ACCESS, $urandom_range(1), $urandom_range(63), $urandom_range(255), $urandom);
      end else if (r < 96) begin
        send(REQ_VICTIM, $urandom_range(1), $urandom_range(63), $urandom_range(255), $urandom);
      end else begin
        send(REQ_NOP, $urandom_range(1), $urandom_range(63), $urandom_range(255), $urandom);
      end
    end
    steady = 0;
  endtask

  initial begin
    for (int f = 0; f < 64; f++) known[f] = 0;
    repeat (8) @(posedge clk);
    rst_n <= 1;
    @(posedge clk);

    // Empty set, miss, no-op, tag extremes, duplicate tags, overwrite.
    send(REQ_VICTIM, 0, 0, 0, 0);
    send(REQ_ACCESS, 0, 0, 8'hff, 16'hffff);
    send(REQ_NOP, 1, 63, 8'hff, 16'hffff);
    send(REQ_INSTALL, 0, 0, 8'h00, 16'h0000);
    send(REQ_INSTALL, 1, 63, 8'hff, 16'hffff);
    send(REQ_INSTALL, 0, 5, 8'h00, 16'h0000);
    send(REQ_ACCESS, 1, 0, 8'h00, 16'h0000);
    send(REQ_ACCESS, 0, 0, 8'hff, 16'hffff);
    send(REQ_INSTALL, 0, 63, 8'h5a, 16'ha5a5);
    send(REQ_ACCESS, 1, 0, 8'h5a, 16'ha5a5);
    send(REQ_VICTIM, 0, 0, 0, 0);
    send(REQ_VICTIM, 0, 0, 0, 0);
    send(REQ_VICTIM, 0, 0, 0, 0);
    send(REQ_VICTIM, 0, 0, 0, 0);
    random_items(300);

    set_phase(1, 1);
    send(REQ_INSTALL, 0, 1, 8'h12, 16'h3456);
    send(REQ_INSTALL, 0, 0, 8'h12, 16'h3456);
    send(REQ_VICTIM, 0, 0, 0, 0);
    random_items(300);

    set_phase(0, 17);
    random_items(300);

    set_phase(1, 64);
    random_items(300);

    in_tvalid <= 0;
    @(posedge clk);
    while (pending != 0) @(posedge clk);
    repeat (20) @(posedge clk);
    if (errors == 0) $display("SCOREBOARD CLEAN");
    else $display("SCOREBOARD MISMATCH");
    $finish;
  end

endmodule

// File: sim.f
+incdir+src
src/prcl_pkg.sv
src/prcl_cell.sv
src/page_replacement_clockm_lru.sv
test/page_replacement_clockm_lru_checker.sv
test/page_replacement_clockm_lru_tb.sv
